>>> design/light_scene_dimmer_defines.svh
// assertion helpers for the scene dimmer
// each expects clk and arst_n in the including module
`ifndef LIGHT_SCENE_DIMMER_DEFINES_SVH
`define LIGHT_SCENE_DIMMER_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define LSD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define LSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/lsd_pkg.sv
`default_nettype none
package lsd_pkg;

	// request command codes
	localparam logic [1:0] CMD_CALL    = 2'd0;
	localparam logic [1:0] CMD_CAPTURE = 2'd1;
	localparam logic [1:0] CMD_PRIO    = 2'd2;
	localparam logic [1:0] CMD_LOAD    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_MIN       = 2'd1;
	localparam logic [1:0] REG_MAX       = 2'd2;
	localparam logic [1:0] REG_DIMMABLE  = 2'd3;

	// special scenes
	localparam logic [6:0] SC_DEC  = 7'd11;
	localparam logic [6:0] SC_INC  = 7'd12;
	localparam logic [6:0] SC_MIN  = 7'd13;
	localparam logic [6:0] SC_STOP = 7'd15;
	localparam logic [6:0] LAST_DEFAULT = 7'd80;

	localparam logic [7:0] DIM_STEP   = 8'd11;
	localparam logic [7:0] FULL_LEVEL = 8'd255;
	localparam logic [7:0] INC_LIMIT  = FULL_LEVEL - DIM_STEP;

	localparam int FLAG_DONT_CARE   = 0;
	localparam int FLAG_IGNORE_PRIO = 1;

	localparam logic [7:0] DFLT_LEVEL [0:80] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd192, 8'd128, 8'd64,
		8'd192, 8'd128, 8'd64,  8'd192, 8'd168, 8'd64,  8'd192, 8'd168, 8'd64,  8'd192,
		8'd168, 8'd64,  8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
		8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   8'd0,
		8'd0
	};

	// bit 0 dont-care, bit 1 ignore-priority
	localparam logic [1:0] DFLT_FLAGS [0:80] = '{
		2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd2, 2'd0, 2'd0, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0,
		2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
		2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
		2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1,
		2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd2,
		2'd3, 2'd3, 2'd2, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
		2'd1
	};

	// what the back end has to do with one request
	typedef enum logic [2:0] {
		K_NOP,
		K_DEC,
		K_INC,
		K_MIN,
		K_CALL,
		K_CAPTURE,
		K_PRIO,
		K_LOAD
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] scene;
		logic [7:0] value;
		logic [7:0] dflt_level;
		logic [1:0] flags;
	} op_t;

	typedef struct packed {
		logic [7:0] drive_value;
		logic       drive_update;
		logic       slow_transition;
		logic [7:0] brightness_now;
		logic       lamp_on;
	} res_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} exec_state_t;

endpackage
`default_nettype wire

>>> design/light_scene_dimmer.sv
// light_scene_dimmer: scene controller for one lamp. a front end classifies each request
// (call, capture, set priority, load brightness) and queues it; a back end keeps the
// brightness, on and priority state and a per-scene level store, and queues one result
// per request. the back end reads the scene level store for a request, then executes it:
// computes, updates state, writes a capture back and stalls on a full result queue. only
// then is the next request fetched. results stay queued until popped, and requests keep
// being taken while the input queue has room. the level store needs no clearing pass
// after reset: each scene has a valid bit, and an uncaptured scene reads its default.
`default_nettype none
module light_scene_dimmer
	import lsd_pkg::*;
#(
	parameter int NUM_SCENES = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// request side
	input  wire logic       push,
	output logic            full,
	input  wire logic [1:0] command,
	input  wire logic [6:0] scene_number,
	input  wire logic [7:0] value,
	// result side
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      drive_value,
	output logic            drive_update,
	output logic            slow_transition,
	output logic [7:0]      brightness_now,
	output logic            lamp_on,
	// configuration writes
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int OP_DEPTH  = 2;
	localparam int RES_DEPTH = 2;

	// front to back queue
	op_t  op_in;
	op_t  op_out;
	logic op_push;
	logic op_full;
	logic op_empty;
	logic op_pop;

	// back to output queue
	res_t res_in;
	res_t res_out;
	logic res_push;
	logic res_full;

	lsd_front #(
		.NUM_SCENES(NUM_SCENES)
	) u_front (
		.push        (push),
		.full        (full),
		.command     (command),
		.scene_number(scene_number),
		.value       (value),
		.op_push     (op_push),
		.op          (op_in),
		.op_full     (op_full)
	);

	// decouples classification from execution
	lsd_fifo #(
		.WIDTH($bits(op_t)),
		.DEPTH(OP_DEPTH)
	) u_op_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (op_push),
		.wdata (op_in),
		.full  (op_full),
		.pop   (op_pop),
		.rdata (op_out),
		.empty (op_empty)
	);

	lsd_back #(
		.NUM_SCENES(NUM_SCENES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.op_valid (!op_empty),
		.op       (op_out),
		.op_pop   (op_pop),
		.res_push (res_push),
		.res      (res_in),
		.res_full (res_full)
	);

	// finished results wait here until popped
	lsd_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign drive_value     = res_out.drive_value;
	assign drive_update    = res_out.drive_update;
	assign slow_transition = res_out.slow_transition;
	assign brightness_now  = res_out.brightness_now;
	assign lamp_on         = res_out.lamp_on;

endmodule
`default_nettype wire

>>> design/lsd_ram.sv
`default_nettype none
module lsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/lsd_fifo.sv
`default_nettype none
module lsd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/lsd_front.sv
`default_nettype none
module lsd_front
	import lsd_pkg::*;
#(
	parameter int NUM_SCENES = 128
) (
	input  wire logic       push,
	output logic            full,
	input  wire logic [1:0] command,
	input  wire logic [6:0] scene_number,
	input  wire logic [7:0] value,
	output logic            op_push,
	output op_t             op,
	input  wire logic       op_full
);

	localparam logic [8:0] SCENE_LIMIT = 9'(NUM_SCENES);

	logic       in_store;
	logic [6:0] dflt_idx;

	assign full     = op_full;
	assign op_push  = push && !op_full;
	assign in_store = ({2'b00, scene_number} < SCENE_LIMIT);
	// scenes past the table share its last entry
	assign dflt_idx = (scene_number > LAST_DEFAULT) ? LAST_DEFAULT : scene_number;

	always_comb begin
		op.scene      = scene_number;
		op.value      = value;
		op.dflt_level = DFLT_LEVEL[dflt_idx];
		op.flags      = DFLT_FLAGS[dflt_idx];
		op.kind       = K_NOP;
		case (command)
			CMD_CALL: begin
				if (scene_number == SC_DEC) begin
					op.kind = K_DEC;
				end else if (scene_number == SC_INC) begin
					op.kind = K_INC;
				end else if (scene_number == SC_MIN) begin
					op.kind = K_MIN;
				end else if (scene_number == SC_STOP) begin
					op.kind = K_NOP;
				end else if (in_store) begin
					op.kind = K_CALL;
				end
			end
			CMD_CAPTURE: begin
				if (in_store) begin
					op.kind = K_CAPTURE;
				end
			end
			CMD_PRIO: begin
				op.kind = K_PRIO;
			end
			CMD_LOAD: begin
				op.kind = K_LOAD;
			end
			default: begin
				op.kind = K_NOP;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> design/lsd_back.sv
`default_nettype none
`include "light_scene_dimmer_defines.svh"
module lsd_back
	import lsd_pkg::*;
#(
	parameter int NUM_SCENES = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       op_valid,
	input  wire op_t        op,
	output logic            op_pop,
	output logic            res_push,
	output res_t            res,
	input  wire logic       res_full
);

	localparam int AW = $clog2(NUM_SCENES);

	exec_state_t state_q;
	exec_state_t state_nxt;

	logic [7:0] thr_q;
	logic [7:0] min_q;
	logic [7:0] max_q;
	logic       dim_q;

	logic [7:0] lvl_q;
	logic       on_q;
	logic       prio_q;
	logic       valid_q [NUM_SCENES];

	op_t        op_s1;
	logic       valid_s1;
	logic [7:0] ram_rdata;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;

	logic [7:0] eff_min;
	logic [7:0] stored_lvl;
	logic [7:0] step_lvl;
	logic [7:0] nxt_lvl;
	logic       nxt_on;
	logic       nxt_prio;
	logic       upd;
	logic       slow;
	logic       capture;
	logic       finish;

	assign raddr  = AW'(op.scene);
	assign waddr  = AW'(op_s1.scene);
	assign finish = (state_q == ST_EXEC) && !res_full;

	lsd_ram #(
		.WIDTH(8),
		.DEPTH(NUM_SCENES)
	) u_level_ram (
		.clk  (clk),
		.we   (capture),
		.waddr(waddr),
		.wdata(lvl_q),
		.re   (op_pop),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// sequencer: fetch then execute
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (op_valid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!res_full) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		op_pop   = 1'b0;
		res_push = 1'b0;
		case (state_q)
			ST_IDLE: begin
				op_pop = op_valid;
			end
			ST_EXEC: begin
				res_push = !res_full;
			end
			default: begin
				op_pop   = 1'b0;
				res_push = 1'b0;
			end
		endcase
	end

	// never-captured scenes read their default level
	assign stored_lvl = valid_s1 ? ram_rdata : op_s1.dflt_level;
	assign eff_min    = (min_q == 8'd0) ? 8'd1 : min_q;

	always_comb begin
		step_lvl = lvl_q;
		if (op_s1.kind == K_DEC) begin
			step_lvl = (lvl_q > DIM_STEP) ? lvl_q - DIM_STEP : 8'd1;
			if (step_lvl < eff_min) begin
				step_lvl = eff_min;
			end
		end else begin
			step_lvl = (lvl_q < INC_LIMIT) ? lvl_q + DIM_STEP : FULL_LEVEL;
			if (step_lvl > max_q) begin
				step_lvl = max_q;
			end
		end
	end

	always_comb begin
		nxt_lvl  = lvl_q;
		nxt_on   = on_q;
		nxt_prio = prio_q;
		upd      = 1'b0;
		slow     = 1'b0;
		capture  = 1'b0;
		case (op_s1.kind)
			K_DEC, K_INC: begin
				if (on_q && !prio_q && (step_lvl != lvl_q)) begin
					nxt_lvl = step_lvl;
					nxt_on  = (step_lvl != 8'd0);
					upd     = 1'b1;
					slow    = 1'b1;
				end
			end
			K_MIN: begin
				nxt_lvl = eff_min;
				nxt_on  = 1'b1;
				upd     = 1'b1;
			end
			K_CALL: begin
				if (!op_s1.flags[FLAG_DONT_CARE] &&
					(!prio_q || op_s1.flags[FLAG_IGNORE_PRIO])) begin
					nxt_lvl = stored_lvl;
					nxt_on  = (stored_lvl != 8'd0);
					upd     = 1'b1;
				end
			end
			K_CAPTURE: begin
				capture = finish;
			end
			K_PRIO: begin
				nxt_prio = op_s1.value[0];
			end
			K_LOAD: begin
				nxt_lvl = op_s1.value;
				nxt_on  = on_q || (op_s1.value != 8'd0);
			end
			default: begin
				nxt_lvl = lvl_q;
			end
		endcase
	end

	always_comb begin
		res.drive_value = 8'd0;
		if (upd && nxt_on) begin
			if (dim_q) begin
				res.drive_value = nxt_lvl;
			end else if (nxt_lvl >= thr_q) begin
				res.drive_value = FULL_LEVEL;
			end
		end
		res.drive_update    = upd;
		res.slow_transition = slow;
		res.brightness_now  = nxt_lvl;
		res.lamp_on         = nxt_on;
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_s1    <= op;
			valid_s1 <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			thr_q   <= 8'd128;
			min_q   <= 8'd1;
			max_q   <= 8'd255;
			dim_q   <= 1'b1;
			lvl_q   <= 8'd0;
			on_q    <= 1'b0;
			prio_q  <= 1'b0;
			for (int i = 0; i < NUM_SCENES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD: thr_q <= cfg_data;
					REG_MIN:       min_q <= cfg_data;
					REG_MAX:       max_q <= cfg_data;
					REG_DIMMABLE:  dim_q <= cfg_data[0];
					default:       dim_q <= dim_q;
				endcase
			end
			if (finish) begin
				lvl_q  <= nxt_lvl;
				on_q   <= nxt_on;
				prio_q <= nxt_prio;
			end
			if (capture) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	`LSD_ASSERT_NOW(a_exec_delivers, (state_q == ST_EXEC) && !res_full, res_push,
		"execute stage with room did not deliver")
	`LSD_ASSERT_NOW(a_no_push_full, res_push, !res_full, "result pushed into full queue")
	`LSD_ASSERT_NOW(a_slow_needs_update, res_push && res.slow_transition, res.drive_update,
		"slow transition without drive update")
	`LSD_ASSERT_NOW(a_quiet_drive, res_push && !res.drive_update, res.drive_value == 8'd0,
		"drive value set without update")
	`LSD_ASSERT_NEXT(a_fetch_to_exec, op_pop, state_q == ST_EXEC,
		"fetched request not executed next")

endmodule
`default_nettype wire

>>> sim/tb_light_scene_dimmer.sv
module tb_light_scene_dimmer
	import lsd_pkg::*;
;

	localparam int SCENE_COUNT = 128;

	// one request as it goes into the block
	typedef struct packed {
		logic [1:0] command;
		logic [6:0] scene;
		logic [7:0] value;
	} dimmer_req_t;

	// clock, reset and block ports; the driven ones are known from time zero
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [1:0] command = CMD_CALL;
	logic [6:0] scene_number = '0;
	logic [7:0] value = '0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] drive_value;
	logic       drive_update;
	logic       slow_transition;
	logic [7:0] brightness_now;
	logic       lamp_on;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_THRESHOLD;
	logic [7:0] cfg_data = '0;

	// requests waiting for the driver, results waiting for the block
	dimmer_req_t commands_pending[$];
	res_t        lamp_results_due[$];

	// idling knobs, percent of cycles
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	bit          push_taken = 1'b0;
	bit          failed = 1'b0;
	dimmer_req_t next_req;
	res_t        want;

	// lamp state mirror
	logic [7:0] lamp_level;
	logic       lamp_is_on;
	logic       prio_held;
	logic [7:0] scene_lvls [0:SCENE_COUNT-1];
	logic [1:0] scene_flg [0:SCENE_COUNT-1];

	// register mirror, reset values
	logic [7:0] cfg_thr = 8'd128;
	logic [7:0] cfg_min = 8'd1;
	logic [7:0] cfg_max = 8'd255;
	logic       cfg_dim = 1'b1;

	light_scene_dimmer u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.command         (command),
		.scene_number    (scene_number),
		.value           (value),
		.empty           (empty),
		.pop             (pop),
		.drive_value     (drive_value),
		.drive_update    (drive_update),
		.slow_transition (slow_transition),
		.brightness_now  (brightness_now),
		.lamp_on         (lamp_on),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the lamp mirror by one request and return the result it owes
	function automatic res_t apply_scene_command(input dimmer_req_t rq);
		res_t       r;
		logic [7:0] floor_lvl;
		int         nxt_lvl;
		logic       changed;
		logic       ramp;
		logic [1:0] fl;
		floor_lvl = (cfg_min == 8'd0) ? 8'd1 : cfg_min;
		changed = 1'b0;
		ramp = 1'b0;
		case (rq.command)
			CMD_CALL: begin
				if (rq.scene == SC_DEC || rq.scene == SC_INC) begin
					// dim steps only move a lamp that is on and not held by priority
					if (lamp_is_on && !prio_held) begin
						if (rq.scene == SC_DEC) begin
							nxt_lvl = (lamp_level > DIM_STEP) ? lamp_level - DIM_STEP : 1;
							if (nxt_lvl < floor_lvl)
								nxt_lvl = floor_lvl;
						end else begin
							nxt_lvl = (lamp_level < INC_LIMIT) ? lamp_level + DIM_STEP
								: FULL_LEVEL;
							// max below min still caps here
							if (nxt_lvl > cfg_max)
								nxt_lvl = cfg_max;
						end
						if (nxt_lvl != lamp_level) begin
							lamp_is_on = (nxt_lvl != 0);
							lamp_level = nxt_lvl[7:0];
							changed = 1'b1;
							ramp = 1'b1;
						end
					end
				end else if (rq.scene == SC_STOP) begin
					// stop: nothing moves
				end else if (rq.scene == SC_MIN) begin
					lamp_is_on = 1'b1;
					lamp_level = floor_lvl;
					changed = 1'b1;
				end else begin
					fl = scene_flg[rq.scene];
					if (!fl[FLAG_DONT_CARE] && (!prio_held || fl[FLAG_IGNORE_PRIO])) begin
						lamp_level = scene_lvls[rq.scene];
						lamp_is_on = (lamp_level != 8'd0);
						changed = 1'b1;
					end
				end
			end
			CMD_CAPTURE: scene_lvls[rq.scene] = lamp_level;
			CMD_PRIO: prio_held = rq.value[0];
			CMD_LOAD: begin
				lamp_level = rq.value;
				if (rq.value != 8'd0)
					lamp_is_on = 1'b1;
			end
			default: ;
		endcase
		// off lamp drives 0, non-dimmable lamp drives full or nothing
		if (!changed || !lamp_is_on)
			r.drive_value = 8'd0;
		else if (cfg_dim)
			r.drive_value = lamp_level;
		else
			r.drive_value = (lamp_level >= cfg_thr) ? FULL_LEVEL : 8'd0;
		r.drive_update = changed;
		r.slow_transition = changed & ramp;
		r.brightness_now = lamp_level;
		r.lamp_on = lamp_is_on;
		return r;
	endfunction

	// random request, biased toward sequences that keep the lamp on and dimming
	function automatic dimmer_req_t random_command();
		dimmer_req_t rq;
		int          pick;
		rq.scene = 7'($urandom_range(SCENE_COUNT - 1));
		rq.value = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 45) begin
			rq.command = CMD_CALL;
			if ($urandom_range(99) < 45) begin
				case ($urandom_range(5))
					0, 1: rq.scene = SC_DEC;
					2, 3: rq.scene = SC_INC;
					4: rq.scene = SC_MIN;
					default: rq.scene = SC_STOP;
				endcase
			end
		end else if (pick < 58) begin
			rq.command = CMD_CAPTURE;
		end else if (pick < 68) begin
			rq.command = CMD_PRIO;
			// keep priority off most of the time so dim steps act
			if ($urandom_range(99) < 55)
				rq.value[0] = 1'b0;
		end else begin
			rq.command = CMD_LOAD;
			if ($urandom_range(9) == 0)
				rq.value = $urandom_range(1) ? 8'd255 : 8'd0;
		end
		return rq;
	endfunction

	task automatic queue_command(input logic [1:0] cmd, input logic [6:0] sc,
			input logic [7:0] val);
		commands_pending.push_back('{command: cmd, scene: sc, value: val});
	endtask

	// block is idle once every request went in and every result came back
	task automatic wait_all_done();
		while (commands_pending.size() != 0 || push || lamp_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_THRESHOLD: cfg_thr = data;
			REG_MIN: cfg_min = data;
			REG_MAX: cfg_max = data;
			default: cfg_dim = data[0];
		endcase
	endtask

	task automatic load_lamp_setup(input logic [7:0] thr, input logic [7:0] mn,
			input logic [7:0] mx, input logic dim);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_MIN, mn);
		write_reg(REG_MAX, mx);
		write_reg(REG_DIMMABLE, {7'd0, dim});
	endtask

	// request driver: holds a request until taken, may idle between requests
	always @(negedge clk) begin
		if (arst_n) begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
			if (!push || push_taken) begin
				if (commands_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = commands_pending.pop_front();
					push <= 1'b1;
					command <= next_req.command;
					scene_number <= next_req.scene;
					value <= next_req.value;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: check popped results, predict on every taken request
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (lamp_results_due.size() == 0) begin
					$error("result popped with none expected");
					failed = 1'b1;
				end else begin
					want = lamp_results_due.pop_front();
					if (drive_value !== want.drive_value) begin
						$error("drive_value: expected %0d, got %0d", want.drive_value,
							drive_value);
						failed = 1'b1;
					end
					if (drive_update !== want.drive_update) begin
						$error("drive_update: expected %0d, got %0d", want.drive_update,
							drive_update);
						failed = 1'b1;
					end
					if (slow_transition !== want.slow_transition) begin
						$error("slow_transition: expected %0d, got %0d",
							want.slow_transition, slow_transition);
						failed = 1'b1;
					end
					if (brightness_now !== want.brightness_now) begin
						$error("brightness_now: expected %0d, got %0d",
							want.brightness_now, brightness_now);
						failed = 1'b1;
					end
					if (lamp_on !== want.lamp_on) begin
						$error("lamp_on: expected %0d, got %0d", want.lamp_on, lamp_on);
						failed = 1'b1;
					end
				end
			end
			push_taken = push && !full;
			if (push_taken)
				lamp_results_due.push_back(apply_scene_command(
					'{command: command, scene: scene_number, value: value}));
		end
	end

	initial begin
		#2000000;
		$display("[light_scene_dimmer] ERROR");
		$finish;
	end

	initial begin
		// mirror starts from the default scene table
		lamp_level = 8'd0;
		lamp_is_on = 1'b0;
		prio_held = 1'b0;
		for (int s = 0; s < SCENE_COUNT; s++) begin
			scene_lvls[7'(s)] = DFLT_LEVEL[7'((s > LAST_DEFAULT) ? LAST_DEFAULT : s)];
			scene_flg[7'(s)] = DFLT_FLAGS[7'((s > LAST_DEFAULT) ? LAST_DEFAULT : s)];
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed part, reset settings, no idling
		queue_command(CMD_CALL, 7'd0, 8'd0);       // plain scene, level 0, lamp off
		queue_command(CMD_LOAD, 7'd0, 8'd255);
		queue_command(CMD_CALL, SC_INC, 8'd0);     // already at full, no change
		queue_command(CMD_CALL, SC_DEC, 8'd0);     // slow step down
		queue_command(CMD_LOAD, 7'd0, 8'd5);
		queue_command(CMD_CALL, SC_DEC, 8'd0);     // floors at 1
		queue_command(CMD_CALL, SC_DEC, 8'd0);     // stuck at minimum
		queue_command(CMD_LOAD, 7'd0, 8'd250);
		queue_command(CMD_CALL, SC_INC, 8'd0);     // capped at full
		queue_command(CMD_CALL, SC_MIN, 8'd0);
		queue_command(CMD_CALL, SC_STOP, 8'd0);
		queue_command(CMD_CALL, 7'd16, 8'd0);      // dont-care scene
		queue_command(CMD_PRIO, 7'd0, 8'hFF);
		queue_command(CMD_CALL, 7'd17, 8'd0);      // blocked by priority
		queue_command(CMD_CALL, 7'd1, 8'd0);       // ignores priority
		queue_command(CMD_LOAD, 7'd0, 8'd0);       // zero load keeps on flag
		queue_command(CMD_CALL, SC_INC, 8'd0);     // lamp off, no step
		queue_command(CMD_PRIO, 7'd0, 8'hFE);
		queue_command(CMD_CALL, 7'd5, 8'd0);
		queue_command(CMD_CAPTURE, 7'd127, 8'd0);
		queue_command(CMD_LOAD, 7'd0, 8'h80);
		queue_command(CMD_CAPTURE, 7'd0, 8'd0);
		queue_command(CMD_CALL, 7'd127, 8'd0);     // captured high scene
		queue_command(CMD_CALL, 7'd0, 8'd0);
		queue_command(CMD_CALL, 7'd100, 8'd0);     // high scene takes last default entry

		// random phases, new settings each time the block is idle
		for (int ph = 0; ph < 8; ph++) begin
			wait_all_done();
			repeat (4) @(posedge clk);
			case (ph)
				0: load_lamp_setup(8'($urandom_range(255)), 8'd1, 8'd255, 1'b0);
				1: load_lamp_setup(8'd0, 8'd0, 8'd255, 1'b0);
				2: load_lamp_setup(8'd255, 8'd255, 8'd255, 1'b1);
				3: load_lamp_setup(8'd128, 8'd30, 8'd200, 1'b1);
				4: load_lamp_setup(8'd1, 8'd200, 8'd100, 1'b0);     // max below min
				5: load_lamp_setup(8'($urandom_range(255)), 8'd0, 8'd0, 1'b1);
				6: load_lamp_setup(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 1'($urandom_range(1)));
				default: load_lamp_setup(8'd128, 8'd1, 8'd255, 1'b1);
			endcase
			// idling pattern: none, sender, receiver, both
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 78;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 78;
				end
				default: begin
					send_idle_pct = 9;
					recv_stall_pct = 9;
				end
			endcase
			repeat (82) commands_pending.push_back(random_command());
		end

		wait_all_done();
		repeat (20) @(posedge clk);
		if (!failed && lamp_results_due.size() == 0)
			$display("[light_scene_dimmer] OK");
		else
			$display("[light_scene_dimmer] ERROR");
		$finish;
	end

endmodule
